// ===== src/hsc_pkg.sv =====
// shared types, register codes and lookup tables for the hall six-step commutator
package hsc_pkg;

    localparam int unsigned FuncW   = 2;
    localparam int unsigned HallW   = 3;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned SectorW = 3;
    localparam int unsigned DriveW  = 6;
    localparam int unsigned CountW  = 16;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;

    localparam logic [SectorW-1:0] SECTOR_BAD  = 3'd7;
    localparam logic [SectorW-1:0] SECTOR_LAST = 3'd5;
    localparam logic [SectorW-1:0] SECTOR_HALF = 3'd3;
    localparam logic [FuncW-1:0]   CH_TIMED    = 2'd2;
    localparam logic [DriveW-1:0]  DRIVE_STOP  = 6'h3F;

    typedef enum logic [1:0] {
        REG_INVERT_HALLS  = 2'd0,
        REG_RUN_ENABLE    = 2'd1,
        REG_REQUIRED_DIR  = 2'd2,
        REG_MIN_PERIOD    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_OFF   = 2'd0,
        PH_PLUS  = 2'd1,
        PH_MINUS = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef struct packed {
        logic             invert_halls;
        logic             run_enable;
        logic             dir_cmd;
        logic [TimeW-1:0] min_period;
    } hsc_cfg_t;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [HallW-1:0] hall_bits;
        logic [TimeW-1:0] capture_time;
    } hsc_item_t;

    typedef struct packed {
        logic                     drive_update;
        logic [1:0]               phase_a;
        logic [1:0]               phase_b;
        logic [1:0]               phase_c;
        logic                     rotation_dir;
        logic [SectorW-1:0]       sector_out;
        logic                     hall_fault;
        logic                     interference_fault;
        logic signed [CountW-1:0] start_count;
    } hsc_result_t;

    function automatic logic [SectorW-1:0] hall_to_sector(input logic [HallW-1:0] hall);
        logic [SectorW-1:0] sec;
        case (hall)
            3'd1:    sec = 3'd1;
            3'd2:    sec = 3'd3;
            3'd3:    sec = 3'd2;
            3'd4:    sec = 3'd5;
            3'd5:    sec = 3'd0;
            3'd6:    sec = 3'd4;
            default: sec = SECTOR_BAD;
        endcase
        return sec;
    endfunction

    // phase codes packed as {c, b, a}
    function automatic logic [DriveW-1:0] pattern_code(input logic [SectorW-1:0] k);
        logic [DriveW-1:0] code;
        case (k)
            3'd0:    code = {PH_OFF,   PH_MINUS, PH_PLUS};
            3'd1:    code = {PH_MINUS, PH_OFF,   PH_PLUS};
            3'd2:    code = {PH_MINUS, PH_PLUS,  PH_OFF};
            3'd3:    code = {PH_OFF,   PH_PLUS,  PH_MINUS};
            3'd4:    code = {PH_PLUS,  PH_OFF,   PH_MINUS};
            3'd5:    code = {PH_PLUS,  PH_MINUS, PH_OFF};
            default: code = DRIVE_STOP;
        endcase
        return code;
    endfunction

    // an invalid stored sector counts as the last one, so it wraps to zero
    function automatic logic [SectorW-1:0] next_sector(input logic [SectorW-1:0] s);
        return (s >= SECTOR_LAST) ? '0 : s + 3'd1;
    endfunction

endpackage

// ===== src/hsc_if.sv =====
// request channels: hall capture events in, commutation results out
interface hsc_in_if;
    logic                                valid;
    logic                                ready;
    logic [hsc_pkg::FuncW-1:0]           func;
    logic [hsc_pkg::HallW-1:0]           hall_bits;
    logic [hsc_pkg::TimeW-1:0]           capture_time;

    modport source (output valid, output func, output hall_bits, output capture_time,
                    input ready);
    modport sink   (input valid, input func, input hall_bits, input capture_time,
                    output ready);
endinterface

interface hsc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                drive_update;
    logic [1:0]                          phase_a;
    logic [1:0]                          phase_b;
    logic [1:0]                          phase_c;
    logic                                rotation_dir;
    logic [hsc_pkg::SectorW-1:0]         sector_out;
    logic                                hall_fault;
    logic                                interference_fault;
    logic signed [hsc_pkg::CountW-1:0]   start_count;

    modport source (output valid, output drive_update, output phase_a, output phase_b,
                    output phase_c, output rotation_dir, output sector_out,
                    output hall_fault, output interference_fault, output start_count,
                    input ready);
    modport sink   (input valid, input drive_update, input phase_a, input phase_b,
                    input phase_c, input rotation_dir, input sector_out,
                    input hall_fault, input interference_fault, input start_count,
                    output ready);
endinterface

// ===== src/hsc_apb_regs.sv =====
// apb configuration registers
module hsc_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsc_pkg::AddrW-1:0]   paddr,
    input  logic [hsc_pkg::DataW-1:0]   pwdata,
    output logic [hsc_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output hsc_pkg::hsc_cfg_t           cfg
);

    hsc_pkg::hsc_cfg_t cfg_reg;
    hsc_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = hsc_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                hsc_pkg::REG_INVERT_HALLS: cfg_reg.invert_halls <= pwdata[0];
                hsc_pkg::REG_RUN_ENABLE:   cfg_reg.run_enable   <= pwdata[0];
                hsc_pkg::REG_REQUIRED_DIR: cfg_reg.dir_cmd      <= pwdata[0];
                hsc_pkg::REG_MIN_PERIOD:   cfg_reg.min_period   <= pwdata;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            hsc_pkg::REG_INVERT_HALLS: prdata = {31'd0, cfg_reg.invert_halls};
            hsc_pkg::REG_RUN_ENABLE:   prdata = {31'd0, cfg_reg.run_enable};
            hsc_pkg::REG_REQUIRED_DIR: prdata = {31'd0, cfg_reg.dir_cmd};
            hsc_pkg::REG_MIN_PERIOD:   prdata = cfg_reg.min_period;
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== src/hsc_comm.sv =====
// commutation state and per-event step logic
module hsc_comm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hsc_pkg::hsc_cfg_t     cfg,
    input  logic                  step_en,
    input  hsc_pkg::hsc_item_t    item,
    output hsc_pkg::hsc_result_t  res
);

    logic [hsc_pkg::SectorW-1:0]       sector_now_reg, sector_now_next;
    logic [hsc_pkg::SectorW-1:0]       sector_before_reg;
    logic                              dir_reg, dir_next;
    logic                              dir_timing_reg, dir_timing_next;
    logic [hsc_pkg::TimeW-1:0]         last_time_reg, last_time_next;
    logic [hsc_pkg::DriveW-1:0]        drive_reg, drive_next;
    logic [1:0]                        fault_reg, fault_next;
    logic signed [hsc_pkg::CountW-1:0] count_reg, count_next;

    logic [hsc_pkg::HallW-1:0]         hall;
    logic [hsc_pkg::SectorW-1:0]       pat_idx;
    logic [hsc_pkg::TimeW-1:0]         spacing;
    logic                              sector_ok;

    always_comb
    begin
        // direction from the two stored sectors
        if (sector_now_reg <= hsc_pkg::SECTOR_LAST
            && sector_now_reg == hsc_pkg::next_sector(sector_before_reg))
        begin
            dir_next = 1'b0;
        end
        else if (hsc_pkg::next_sector(sector_now_reg) == sector_before_reg)
        begin
            dir_next = 1'b1;
        end
        else
        begin
            dir_next = cfg.dir_cmd;
        end

        hall            = cfg.invert_halls ? ~item.hall_bits : item.hall_bits;
        sector_now_next = hsc_pkg::hall_to_sector(hall);
        sector_ok       = (sector_now_next != hsc_pkg::SECTOR_BAD);

        // (sector + 3*dir) mod 6
        if (!cfg.dir_cmd)
        begin
            pat_idx = sector_now_next;
        end
        else if (sector_now_next >= hsc_pkg::SECTOR_HALF)
        begin
            pat_idx = sector_now_next - hsc_pkg::SECTOR_HALF;
        end
        else
        begin
            pat_idx = sector_now_next + hsc_pkg::SECTOR_HALF;
        end

        fault_next = fault_reg;
        drive_next = drive_reg;
        if (!sector_ok)
        begin
            fault_next[0] = 1'b1;
        end
        else if (cfg.run_enable)
        begin
            drive_next = hsc_pkg::pattern_code(pat_idx);
        end
        else
        begin
            drive_next = hsc_pkg::DRIVE_STOP;
        end

        count_next = dir_next ? count_reg - 16'sd1 : count_reg + 16'sd1;

        spacing         = item.capture_time - last_time_reg;
        last_time_next  = last_time_reg;
        dir_timing_next = dir_timing_reg;
        if (item.func == hsc_pkg::CH_TIMED)
        begin
            last_time_next  = item.capture_time;
            dir_timing_next = dir_next;
            if (dir_timing_reg == dir_next && spacing < cfg.min_period)
            begin
                fault_next[1] = 1'b1;
            end
        end

        res.drive_update       = sector_ok;
        res.phase_a            = drive_next[1:0];
        res.phase_b            = drive_next[3:2];
        res.phase_c            = drive_next[5:4];
        res.rotation_dir       = dir_next;
        res.sector_out         = sector_now_next;
        res.hall_fault         = fault_next[0];
        res.interference_fault = fault_next[1];
        res.start_count        = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_now_reg    <= '0;
            sector_before_reg <= '0;
            dir_reg           <= 1'b0;
            dir_timing_reg    <= 1'b0;
            last_time_reg     <= '0;
            drive_reg         <= '0;
            fault_reg         <= '0;
            count_reg         <= '0;
        end
        else if (step_en)
        begin
            sector_now_reg    <= sector_now_next;
            sector_before_reg <= sector_now_reg;
            dir_reg           <= dir_next;
            dir_timing_reg    <= dir_timing_next;
            last_time_reg     <= last_time_next;
            drive_reg         <= drive_next;
            fault_reg         <= fault_next;
            count_reg         <= count_next;
        end
    end

    // fault flags only clear through reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (fault_reg & $past(fault_reg)) == $past(fault_reg))
        else $error("fault flag dropped without reset");

    a_sector_code: assert property (@(posedge clk) disable iff (!rst_n)
        sector_now_reg != 3'd6)
        else $error("stored sector holds an unused code");

    // count moves by exactly one per event, following the detected direction
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> ((count_reg == $past(count_reg) + 16'sd1) && !dir_reg)
                 || ((count_reg == $past(count_reg) - 16'sd1) && dir_reg))
        else $error("step count did not follow direction");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(count_reg) && $stable(sector_now_reg) && $stable(drive_reg))
        else $error("state changed without an event");

endmodule

// ===== src/hall_six_step_commutator.sv =====
// top level of the hall six-step commutator
//
// usage:
//   in_ch carries one hall capture request per transfer: func (capture channel),
//   hall_bits and capture_time. out_ch returns exactly one result request for each
//   input request, in order: drive update flag, phase codes, detected direction,
//   sector, sticky fault flags and the signed commutation count.
//   the apb port sets invert_halls, run_enable, the commanded direction and min_period
//   at byte addresses 0, 4, 8 and 12; write it only while no request is in flight.
// flow:
//   a request taken from in_ch lands in the input register, is processed by the
//   commutation logic and is registered into the output register once that is free
//   (empty, or its result being taken), which raises out_ch.valid.
//   one request per cycle sustained while out_ch.ready stays high; the state update happens as the request moves
//   into the output register.
// reset:
//   rst_n clears both pipeline valids, the configuration, the stored sectors,
//   direction, timestamps, drive codes (all phases off), faults and the count.
// stall:
//   when out_ch.ready is low the result holds, one more request is buffered in the
//   input register, and in_ch.ready drops only when both registers are full.
module hall_six_step_commutator (
    input  logic                        clk,
    input  logic                        rst_n,
    hsc_in_if.sink                      in_ch,
    hsc_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsc_pkg::AddrW-1:0]   paddr,
    input  logic [hsc_pkg::DataW-1:0]   pwdata,
    output logic [hsc_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    hsc_pkg::hsc_cfg_t    cfg;
    hsc_pkg::hsc_item_t   in_item_reg;
    hsc_pkg::hsc_result_t res;
    hsc_pkg::hsc_result_t out_res_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 out_load;
    logic                 in_take;

    hsc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hsc_comm u_comm (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (out_load),
        .item    (in_item_reg),
        .res     (res)
    );

    assign out_load    = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || out_load;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.func         <= in_ch.func;
            in_item_reg.hall_bits    <= in_ch.hall_bits;
            in_item_reg.capture_time <= in_ch.capture_time;
        end
        if (out_load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.drive_update       = out_res_reg.drive_update;
    assign out_ch.phase_a            = out_res_reg.phase_a;
    assign out_ch.phase_b            = out_res_reg.phase_b;
    assign out_ch.phase_c            = out_res_reg.phase_c;
    assign out_ch.rotation_dir       = out_res_reg.rotation_dir;
    assign out_ch.sector_out         = out_res_reg.sector_out;
    assign out_ch.hall_fault         = out_res_reg.hall_fault;
    assign out_ch.interference_fault = out_res_reg.interference_fault;
    assign out_ch.start_count        = out_res_reg.start_count;

    // input side blocks only with both stages full and the output stalled
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> in_valid_reg && out_valid_reg && !out_ch.ready)
        else $error("input stalled without a full pipeline");

    // a buffered request always moves on once the output frees up
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_ch.ready |=> out_valid_reg)
        else $error("buffered request not forwarded");

    a_invalid_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.drive_update |-> out_res_reg.hall_fault
            && out_res_reg.sector_out == hsc_pkg::SECTOR_BAD)
        else $error("dropped drive update without hall fault");

endmodule
